FILE: rtl/core/ira_pkg.sv
// Shared types, constants and widths for the infrared range averaging unit.
`default_nettype none
package ira_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 18;
  localparam int unsigned CountW  = 8;
  localparam int unsigned MmW     = 13;
  localparam int unsigned DvsW    = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CfgSensorModel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumAvg      = 2'd1;

  localparam logic [MmW-1:0] MmMax = 13'd4152;

  typedef enum logic [1:0] {
    ModelLong  = 2'd0,
    ModelMid   = 2'd1,
    ModelShort = 2'd2,
    ModelOff   = 2'd3
  } sensor_model_e;

  typedef struct packed {
    logic [SumW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_op_t;

endpackage
`default_nettype wire

FILE: rtl/core/ira_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module ira_div
  import ira_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire div_op_t         op_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [SumW-1:0]      quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW-1:0]    rem_q;
  logic [DvsW-1:0]    dvs_q;
  logic [SumW-1:0]    quo_q;

  logic [DvsW:0]      trial;
  logic [DvsW+1:0]    diff;
  logic               borrow;

  assign trial  = {rem_q, quo_q[SumW-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs_q};
  assign borrow = diff[DvsW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DivCntW'(DivSteps - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= op_i.dividend;
      dvs_q <= op_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[SumW-2:0], ~borrow};
      rem_q <= borrow ? trial[DvsW-1:0] : diff[DvsW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/ira_curve.sv
// Sensor curve operand setup and quotient-to-millimetre scaling.
`default_nettype none
module ira_curve
  import ira_pkg::*;
(
  input  wire sensor_model_e    model_i,
  input  wire logic [SampleW-1:0] mean_i,
  input  wire logic [SumW-1:0]  quot_i,
  output div_op_t               op_o,
  output logic [MmW-1:0]        mm_o
);

  logic [SampleW-1:0] v_long;
  logic [SampleW-1:0] v_mid;
  logic [SampleW-1:0] v_short;
  logic [SumW-1:0]    v_ext;
  logic [SumW-1:0]    v_x11;
  logic [DvsW-1:0]    v_x10;
  logic [MmW-1:0]     q_x10;

  always_comb begin
    v_long  = (mean_i < SampleW'(70)) ? SampleW'(70) : mean_i;
    v_mid   = (mean_i < SampleW'(30)) ? SampleW'(30) : mean_i;
    v_short = (mean_i < SampleW'(16)) ? SampleW'(16) : mean_i;
    v_ext   = SumW'(v_long);
    v_x11   = (v_ext << 3) + (v_ext << 1) + v_ext;
    v_x10   = DvsW'((v_ext << 3) + (v_ext << 1));
    q_x10   = (MmW'(quot_i[7:0]) << 3) + (MmW'(quot_i[7:0]) << 1);

    unique case (model_i)
      ModelLong: begin
        op_o.dividend = SumW'(127773) - v_x11;
        op_o.divisor  = v_x10;
        mm_o          = q_x10;
      end
      ModelMid: begin
        op_o.dividend = SumW'(67870);
        op_o.divisor  = DvsW'(v_mid) - DvsW'(3);
        mm_o          = quot_i[MmW-1:0] - MmW'(40);
      end
      ModelShort: begin
        op_o.dividend = SumW'(20760);
        op_o.divisor  = DvsW'(v_short) - DvsW'(11);
        mm_o          = quot_i[MmW-1:0];
      end
      default: begin
        op_o.dividend = '0;
        op_o.divisor  = DvsW'(1);
        mm_o          = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/ir_range_average_to_distance_unit.sv
// Top level: sample averaging and reciprocal distance conversion.
// An item that does not complete an average is added to the running sum and count.
// An item that completes an average makes two passes of the 18-step bit-serial divider
// (mean, then the curve) before its result is loaded into the output register.
// A new item is taken once the result is in the output register.
// Reset clears the sum, the count and the output valid; the model resets to long range,
// the average length to one.
`default_nettype none
module ir_range_average_to_distance_unit
  import ira_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] adc_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [MmW-1:0]          distance_mm_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMean,
    StPrep,
    StCurve,
    StOut
  } state_e;

  state_e            state_q;
  sensor_model_e     model_q;
  logic [CountW-1:0] num_avg_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic              div_start_q;
  div_op_t           div_op_q;
  logic [SampleW-1:0] mean_q;
  logic [SumW-1:0]   quot_q;
  logic              out_valid_q;
  logic [MmW-1:0]    mm_q;

  logic [SumW-1:0]   sum_d;
  logic [CountW-1:0] count_d;
  logic              in_fire;
  logic              emit;
  logic              div_busy;
  logic              div_done;
  logic [SumW-1:0]   div_quot;
  div_op_t           curve_op;
  logic [MmW-1:0]    curve_mm;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sum_d      = sum_q + SumW'(adc_sample_i);
  assign count_d    = count_q + 1'b1;
  assign emit       = (count_d != '0) && (count_d >= num_avg_q);

  ira_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .op_i    (div_op_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ira_curve u_curve (
    .model_i (model_q),
    .mean_i  (mean_q),
    .quot_i  (quot_q),
    .op_o    (curve_op),
    .mm_o    (curve_mm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      model_q     <= ModelLong;
      num_avg_q   <= CountW'(1);
      sum_q       <= '0;
      count_q     <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= (state_q == StPrep) || (in_fire && emit);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgSensorModel: model_q   <= sensor_model_e'(cfg_data_i[1:0]);
          CfgNumAvg:      num_avg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (emit) begin
              div_op_q    <= '{dividend: sum_d, divisor: DvsW'(count_d)};
              sum_q       <= '0;
              count_q     <= '0;
              state_q     <= StMean;
            end else begin
              sum_q   <= sum_d;
              count_q <= count_d;
            end
          end
        end
        StMean: begin
          if (div_done) begin
            mean_q  <= div_quot[SampleW-1:0];
            state_q <= StPrep;
          end
        end
        StPrep: begin
          div_op_q    <= curve_op;
          state_q     <= StCurve;
        end
        StCurve: begin
          if (div_done) begin
            quot_q  <= div_quot;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            mm_q        <= curve_mm;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_mm_o = mm_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StMean || state_q == StCurve))
    else $error("divider finished outside a wait state");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !div_busy)
    else $error("divider busy while idle");

  a_emit_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> (state_q == StMean && div_start_q && count_q == '0))
    else $error("completed average did not start the mean division");

  a_mm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_mm_o <= MmMax))
    else $error("distance out of range");

endmodule
`default_nettype wire
